[rtl/sksl_pkg.sv]
`default_nettype none
package sksl_pkg;

  // Slot count of the table; kept a power of two so the index wraps by masking.
  localparam int TABLE_SLOTS = 4096;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);

  localparam int SLOT_W   = 12;
  localparam int STATUS_W = 2;
  localparam int HASH_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 13;

  localparam logic [HASH_W-1:0]  HASH_SEED   = 64'd5381;
  localparam int                 HASH_SHIFT  = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 2'd0,
    ST_CLAIMED = 2'd1,
    ST_FULL    = 2'd2
  } sksl_status_t;

  typedef struct packed {
    logic clear;     // clearing pass writes one entry
    logic accept;    // input word taken this cycle
    logic rd;        // issue table read for current probe step
    logic eval;      // compare read data, claim or finish
    logic step;      // advance to next probe step
    logic out_load;  // move result into output register
  } sksl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic key_end;
    logic probe_done;
    logic out_free;
  } sksl_stat_t;

endpackage
`default_nettype wire

[rtl/sksl_in_if.sv]
`default_nettype none
interface sksl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [sksl_pkg::BYTE_W-1:0] name_byte;
  logic                        last;
  logic [sksl_pkg::SLOT_W-1:0] slot_index;

  modport source (output valid, action, name_byte, last, slot_index, input ready);
  modport sink   (input valid, action, name_byte, last, slot_index, output ready);
endinterface
`default_nettype wire

[rtl/sksl_out_if.sv]
`default_nettype none
interface sksl_out_if;
  logic                          valid;
  logic                          ready;
  logic [sksl_pkg::SLOT_W-1:0]   slot;
  logic [sksl_pkg::STATUS_W-1:0] status;
  logic [sksl_pkg::HASH_W-1:0]   key_hash;

  modport source (output valid, slot, status, key_hash, input ready);
  modport sink   (input valid, slot, status, key_hash, output ready);
endinterface
`default_nettype wire

[rtl/sksl_ctrl.sv]
`default_nettype none
module sksl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sksl_pkg::sksl_stat_t st,
  output sksl_pkg::sksl_cmd_t     cmd
);
  import sksl_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD    = 5'b00100,
    S_CK    = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && st.key_end) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CK;
      end
      S_CK: begin
        cmd.eval = 1'b1;
        if (st.probe_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        // hold the result until the output register can take it
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/sksl_dp.sv]
`default_nettype none
module sksl_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sksl_pkg::sksl_cmd_t           cmd,
  output sksl_pkg::sksl_stat_t               st,
  input  wire logic                          in_action,
  input  wire logic [sksl_pkg::BYTE_W-1:0]   in_name_byte,
  input  wire logic                          in_last,
  input  wire logic [sksl_pkg::SLOT_W-1:0]   in_slot_index,
  input  wire logic                          cfg_we,
  input  wire logic [sksl_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [sksl_pkg::SLOT_W-1:0]        out_slot,
  output logic [sksl_pkg::STATUS_W-1:0]      out_status,
  output logic [sksl_pkg::HASH_W-1:0]        out_key_hash
);
  import sksl_pkg::*;

  localparam int ENTRY_W = HASH_W + 1;

  // entry = {valid, stored hash}
  logic [ENTRY_W-1:0] mem [TABLE_SLOTS];

  logic [LIMIT_W-1:0] probe_limit_r;
  logic [HASH_W-1:0]  run_hash_r, run_hash_nxt;
  logic [HASH_W-1:0]  key_hash_r;
  logic [IDX_W-1:0]   clr_cnt_r;
  logic [LIMIT_W-1:0] step_r;
  logic [IDX_W-1:0]   sq_r;
  logic [IDX_W-1:0]   odd_r;
  logic [IDX_W-1:0]   pidx_r;
  logic [ENTRY_W-1:0] rd_q_r;
  logic [SLOT_W-1:0]  res_slot_r;
  sksl_status_t       res_status_r;
  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [HASH_W-1:0]  out_hash_r;

  logic [HASH_W-1:0]  byte_ext;
  logic [HASH_W-1:0]  hash_add;
  logic [LIMIT_W-1:0] limit_eff;
  logic [LIMIT_W:0]   step_inc;
  logic [IDX_W-1:0]   probe_addr;
  logic               ent_valid, ent_match, last_step;
  logic               free_ok;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  assign byte_ext   = {{(HASH_W-BYTE_W){in_name_byte[BYTE_W-1]}}, in_name_byte};
  assign hash_add   = (run_hash_r << HASH_SHIFT) + run_hash_r + byte_ext;
  assign limit_eff  = (probe_limit_r == '0) ? LIMIT_W'(1) : probe_limit_r;
  assign step_inc   = {1'b0, step_r} + (LIMIT_W+1)'(1);
  assign probe_addr = key_hash_r[IDX_W-1:0] + sq_r;
  assign ent_valid  = rd_q_r[ENTRY_W-1];
  assign ent_match  = rd_q_r[HASH_W-1:0] == key_hash_r;
  assign last_step  = step_inc >= {1'b0, limit_eff};
  assign free_ok    = 32'(in_slot_index) < TABLE_SLOTS;

  always_comb begin
    run_hash_nxt = run_hash_r;
    if (in_name_byte != '0) run_hash_nxt = hash_add;
  end

  assign st.clear_done = clr_cnt_r == IDX_W'(TABLE_SLOTS - 1);
  assign st.key_end    = !in_action && in_last;
  assign st.probe_done = !ent_valid || ent_match || last_step;
  assign st.out_free   = !out_valid_r || out_ready;

  // one write port: clearing pass, free, claim
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pidx_r;
    wr_data = {1'b1, key_hash_r};
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (cmd.accept && in_action) begin
      wr_en   = free_ok;
      wr_addr = IDX_W'(in_slot_index);
      wr_data = '0;
    end else if (cmd.eval && !ent_valid) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_q_r <= mem[probe_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_limit_r <= LIMIT_RESET;
      run_hash_r    <= HASH_SEED;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) probe_limit_r <= cfg_wdata;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (cmd.accept && !in_action) begin
        // drop back to the seed once the key is complete
        run_hash_r <= in_last ? HASH_SEED : run_hash_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !in_action && in_last) begin
      key_hash_r <= run_hash_nxt;
      step_r     <= '0;
      sq_r       <= '0;
      odd_r      <= IDX_W'(1);
    end
    if (cmd.rd) pidx_r <= probe_addr;
    if (cmd.step) begin
      // (i+1)^2 = i^2 + 2i + 1
      step_r <= step_inc[LIMIT_W-1:0];
      sq_r   <= sq_r + odd_r;
      odd_r  <= odd_r + IDX_W'(2);
    end
    if (cmd.eval) begin
      if (!ent_valid) begin
        res_status_r <= ST_CLAIMED;
        res_slot_r   <= SLOT_W'(pidx_r);
      end else if (ent_match) begin
        res_status_r <= ST_HIT;
        res_slot_r   <= SLOT_W'(pidx_r);
      end else begin
        res_status_r <= ST_FULL;
        res_slot_r   <= '0;
      end
    end
    if (cmd.out_load) begin
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
      out_hash_r   <= key_hash_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_slot     = out_slot_r;
  assign out_status   = out_status_r;
  assign out_key_hash = out_hash_r;

endmodule
`default_nettype wire

[rtl/string_keyed_slot_lookup.sv]
`default_nettype none
// Channel   Dir  Words carried
// in_ch     in   action, name_byte, last, slot_index
// out_ch    out  slot, status, key_hash (one per key)
// cfg_*     in   probe_limit write, no read-back
//
// Name bytes and frees are taken back to back while the block is idle. A
// byte marked last starts a probe walk, each probe step a table read then
// a compare, and then hands the result to the output register.
// After reset a clearing pass walks the 4096-entry table, one entry a
// cycle, with in_ch.ready low. A stalled result holds in the output
// register; bytes of the next key are taken meanwhile.
module string_keyed_slot_lookup (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  sksl_in_if.sink                           in_ch,
  sksl_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [sksl_pkg::LIMIT_W-1:0] cfg_wdata
);
  import sksl_pkg::*;

  sksl_cmd_t  cmd;
  sksl_stat_t st;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  sksl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sksl_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_action     (in_ch.action),
    .in_name_byte  (in_ch.name_byte),
    .in_last       (in_ch.last),
    .in_slot_index (in_ch.slot_index),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_slot      (out_ch.slot),
    .out_status    (out_ch.status),
    .out_key_hash  (out_ch.key_hash)
  );

endmodule
`default_nettype wire

[rtl/sksl_chk.sv]
`default_nettype none
module sksl_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sksl_pkg::SLOT_W-1:0]   out_slot,
  input wire logic [sksl_pkg::STATUS_W-1:0] out_status,
  input wire logic [sksl_pkg::HASH_W-1:0]   out_key_hash
);
  import sksl_pkg::*;

  // reset starts the clearing pass, so no word is taken right after it
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) &&
      $stable(out_status) && $stable(out_key_hash))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_HIT || out_status == ST_CLAIMED ||
      out_status == ST_FULL))
    else $error("bad status code");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_slot == '0)
    else $error("full result with nonzero slot");

endmodule

bind string_keyed_slot_lookup sksl_chk u_sksl_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_slot     (out_ch.slot),
  .out_status   (out_ch.status),
  .out_key_hash (out_ch.key_hash)
);
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sksl_pkg::*;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    sksl_status_t      status;
    logic [HASH_W-1:0] key_hash;
  } lookup_t;

  typedef struct {
    int                slen;
    logic [BYTE_W-1:0] b [8];
  } name_t;

  // Mirror of the slot table: tracks the running hash, the slot contents and
  // the probe limit, and holds the lookups still owed by the block.
  class slot_table_mirror;
    logic [HASH_W-1:0]  run_hash;
    bit                 live [TABLE_SLOTS];
    logic [HASH_W-1:0]  stored [TABLE_SLOTS];
    logic [LIMIT_W-1:0] limit;
    lookup_t            pending_lookups[$];
    logic [SLOT_W-1:0]  claimed[$];
    int mismatches;
    int shown;
    int lookups_checked;
    int hits;
    int claims;
    int fulls;

    function new();
      run_hash = HASH_SEED;
      foreach (live[i]) live[i] = 1'b0;
      foreach (stored[i]) stored[i] = '0;
      limit = LIMIT_RESET;
      mismatches = 0;
      shown = 0;
      lookups_checked = 0;
      hits = 0;
      claims = 0;
      fulls = 0;
    endfunction

    static function logic [HASH_W-1:0] mix(logic [HASH_W-1:0] h, logic [BYTE_W-1:0] b);
      return (h << HASH_SHIFT) + h + {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    function lookup_t probe(logic [HASH_W-1:0] h);
      lookup_t r;
      longint unsigned n;
      longint unsigned start;
      longint unsigned idx;
      r.slot = '0;
      r.status = ST_FULL;
      r.key_hash = h;
      start = h % TABLE_SLOTS;
      n = (limit == 0) ? 1 : limit;
      for (longint unsigned i = 0; i < n; i++) begin
        idx = (start + (i * i) % TABLE_SLOTS) % TABLE_SLOTS;
        if (!live[idx]) begin
          live[idx] = 1'b1;
          stored[idx] = h;
          r.slot = SLOT_W'(idx);
          r.status = ST_CLAIMED;
          claimed.push_back(SLOT_W'(idx));
          claims++;
          return r;
        end
        if (stored[idx] == h) begin
          r.slot = SLOT_W'(idx);
          r.status = ST_HIT;
          hits++;
          return r;
        end
      end
      fulls++;
      return r;
    endfunction

    function void take_word(logic act, logic [BYTE_W-1:0] b, logic lst, logic [SLOT_W-1:0] si);
      if (act) begin
        if (si < TABLE_SLOTS) begin
          live[si] = 1'b0;
          stored[si] = '0;
        end
        return;
      end
      if (b != 0) run_hash = mix(run_hash, b);
      if (lst) begin
        pending_lookups.push_back(probe(run_hash));
        run_hash = HASH_SEED;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      // cap the log, keep counting
      if (shown < 50) begin
        shown++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endtask

    task check_lookup(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] status,
                      logic [HASH_W-1:0] h);
      lookup_t e;
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d status %0d hash %h",
                                  slot, status, h));
        return;
      end
      e = pending_lookups.pop_front();
      lookups_checked++;
      if (slot !== e.slot)
        report_mismatch($sformatf("slot got %0d want %0d (hash %h)", slot, e.slot, e.key_hash));
      if (status !== e.status)
        report_mismatch($sformatf("status got %0d want %s (hash %h)", status, e.status.name(),
                                  e.key_hash));
      if (h !== e.key_hash)
        report_mismatch($sformatf("key_hash got %h want %h", h, e.key_hash));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  sksl_in_if  in_ch ();
  sksl_out_if out_ch ();

  string_keyed_slot_lookup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  slot_table_mirror mirror = new();

  bit                src_gaps;
  int                words_sent;
  logic [SLOT_W-1:0] hot [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= LIMIT_RESET;
    in_ch.valid <= 1'b0;
    in_ch.action <= 1'b0;
    in_ch.name_byte <= '0;
    in_ch.last <= 1'b0;
    in_ch.slot_index <= '0;
  end

  task automatic send_word(input logic act, input logic [BYTE_W-1:0] b, input logic lst,
                           input logic [SLOT_W-1:0] si);
    if (src_gaps) begin
      while ($urandom_range(0, 99) < 30) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.name_byte <= b;
    in_ch.last <= lst;
    in_ch.slot_index <= si;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    mirror.take_word(act, b, lst, si);
    words_sent++;
  endtask

  function automatic logic [SLOT_W-1:0] free_target();
    int j;
    logic [SLOT_W-1:0] s;
    if (mirror.claimed.size() == 0 || $urandom_range(0, 3) == 0)
      return SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
    j = $urandom_range(0, mirror.claimed.size() - 1);
    s = mirror.claimed[j];
    mirror.claimed.delete(j);
    return s;
  endfunction

  task automatic send_free();
    send_word(1'b1, BYTE_W'($urandom), 1'($urandom), free_target());
  endtask

  task automatic send_key(input name_t k);
    for (int i = 0; i < k.slen; i++) begin
      // occasionally slip a free between bytes; the key hash must survive it
      if (i > 0 && $urandom_range(0, 19) == 0) send_free();
      send_word(1'b0, k.b[i], i == k.slen - 1, SLOT_W'($urandom));
    end
  endtask

  function automatic name_t random_name();
    name_t k;
    k.slen = $urandom_range(1, 8);
    for (int i = 0; i < 8; i++)
      k.b[i] = ($urandom_range(0, 9) == 0) ? '0 : BYTE_W'($urandom);
    return k;
  endfunction

  // Build a key whose hash lands on start slot tgt: random prefix, then pick
  // the last byte so the signed add closes the gap.
  function automatic name_t name_at(input logic [SLOT_W-1:0] tgt);
    name_t k;
    logic [HASH_W-1:0] h;
    logic [SLOT_W-1:0] d;
    bit found;
    found = 1'b0;
    while (!found) begin
      k.slen = $urandom_range(2, 4);
      h = HASH_SEED;
      for (int i = 0; i < k.slen - 1; i++) begin
        k.b[i] = BYTE_W'($urandom_range(1, 255));
        h = slot_table_mirror::mix(h, k.b[i]);
      end
      d = tgt - SLOT_W'((h << HASH_SHIFT) + h);
      if (d != 0 && (d < 128 || d >= TABLE_SLOTS - 128)) begin
        k.b[k.slen-1] = d[BYTE_W-1:0];
        found = 1'b1;
      end
    end
    return k;
  endfunction

  // Hold until nothing is owed, then let a free or stray byte settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (mirror.pending_lookups.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.limit = v;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int words, input bit gaps);
    int first;
    int pick;
    name_t pool[$];
    name_t k;
    write_limit(lim);
    src_gaps = gaps;
    hot[0] = SLOT_W'(TABLE_SLOTS - 1);
    for (int s = 1; s < 4; s++) hot[s] = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
    first = words_sent;
    while (words_sent - first < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        k = random_name();
        send_key(k);
        if (pool.size() < 64) pool.push_back(k);
        else pool[$urandom_range(0, 63)] = k;
      end else if (pick < 65 && pool.size() != 0) begin
        send_key(pool[$urandom_range(0, pool.size() - 1)]);
      end else if (pick < 85) begin
        send_key(name_at(hot[$urandom_range(0, 3)]));
      end else begin
        send_free();
      end
    end
  endtask

  // result side: random stalls, one long hold-off, one stretch with none
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        mirror.check_lookup(out_ch.slot, out_ch.status, out_ch.key_hash);
      if (!held && mirror.lookups_checked == 100) begin
        held = 1'b1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (mirror.lookups_checked >= 200 && mirror.lookups_checked < 320) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin
    name_t k_a;
    name_t k;
    words_sent = 0;
    src_gaps = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // claim, then hit on the same key
    k_a.slen = 1;
    k_a.b[0] = 8'h41;
    send_key(k_a);
    send_key(k_a);
    // signed byte extremes
    k.slen = 4;
    k.b[0] = 8'h80;
    k.b[1] = 8'hFF;
    k.b[2] = 8'h7F;
    k.b[3] = 8'h01;
    send_key(k);
    // NUL inside a key, NUL as the last byte, and an empty key
    k.slen = 3;
    k.b[0] = 8'h12;
    k.b[1] = 8'h00;
    k.b[2] = 8'h34;
    send_key(k);
    k.slen = 2;
    k.b[0] = 8'h5A;
    k.b[1] = 8'h00;
    send_key(k);
    k.slen = 1;
    k.b[0] = 8'h00;
    send_key(k);
    // free in the middle of a key leaves its hash alone
    send_word(1'b0, 8'h55, 1'b0, '0);
    send_word(1'b1, 8'hFF, 1'b1, SLOT_W'(TABLE_SLOTS - 1));
    send_word(1'b0, 8'h66, 1'b1, '1);
    // free the first key's slot, then claim it again
    send_word(1'b1, 8'h00, 1'b0, mirror.claimed[0]);
    send_key(k_a);
    send_word(1'b1, 8'hA5, 1'b0, '0);

    // full table through a start-slot collision with limits 1 and 0, and a second probe step with limit 2
    write_limit(LIMIT_W'(1));
    send_key(name_at(SLOT_W'(7)));
    send_key(name_at(SLOT_W'(7)));
    write_limit('0);
    send_key(name_at(SLOT_W'(7)));
    write_limit(LIMIT_W'(2));
    send_key(name_at(SLOT_W'(7)));

    run_phase(LIMIT_RESET, 300, 1'b1);
    run_phase(LIMIT_W'(3), 300, 1'b1);
    run_phase('1, 300, 1'b0);
    run_phase(LIMIT_W'(1), 300, 1'b1);
    run_phase(LIMIT_W'(6), 300, 1'b1);
    run_phase(LIMIT_RESET, 300, 1'b1);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (mirror.pending_lookups.size() != 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d words; checked %0d lookups: %0d hits, %0d claims, %0d full.",
             words_sent, mirror.lookups_checked, mirror.hits, mirror.claims, mirror.fulls);
    $display("Probe limits 4096, 1, 0, 2, 3, 8191 and 6; %0d mismatches.", mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d lookups outstanding.", mirror.pending_lookups.size());
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/sksl_pkg.sv
rtl/sksl_in_if.sv
rtl/sksl_out_if.sv
rtl/sksl_ctrl.sv
rtl/sksl_dp.sv
rtl/string_keyed_slot_lookup.sv
rtl/sksl_chk.sv
tb/sv/testbench.sv
